// File: sv/lkds_pkg.sv
// Shared types, key codes, register map and reset values for the ladder keypad block.
// Used by every module of the block; it depends on nothing else.
package lkds_pkg;

    // Key codes carried from the front end to the back end.
    localparam logic [2:0] KEY_NONE   = 3'd0;
    localparam logic [2:0] KEY_RIGHT  = 3'd1;
    localparam logic [2:0] KEY_UP     = 3'd2;
    localparam logic [2:0] KEY_DOWN   = 3'd3;
    localparam logic [2:0] KEY_LEFT   = 3'd4;
    localparam logic [2:0] KEY_SELECT = 3'd5;

    // Register indexes; byte address is four times the index.
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_UP       = 3'd1;
    localparam logic [2:0] REG_DOWN     = 3'd2;
    localparam logic [2:0] REG_LEFT     = 3'd3;
    localparam logic [2:0] REG_SELECT   = 3'd4;
    localparam logic [2:0] REG_RELEASE  = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;
    localparam logic [2:0] REG_CENTER   = 3'd7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_DEBOUNCE = 16'd80;
    localparam logic [9:0]  RST_UP       = 10'd130;
    localparam logic [9:0]  RST_DOWN     = 10'd310;
    localparam logic [9:0]  RST_LEFT     = 10'd490;
    localparam logic [9:0]  RST_SELECT   = 10'd720;
    localparam logic [9:0]  RST_RELEASE  = 10'd1000;
    localparam logic [6:0]  RST_LIMIT    = 7'd90;
    localparam logic [7:0]  RST_CENTER   = 8'd92;

    // Default depth of the event queue between front and back end.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] debounce_interval;
        logic [9:0]  up_threshold;
        logic [9:0]  down_threshold;
        logic [9:0]  left_threshold;
        logic [9:0]  select_threshold;
        logic [9:0]  release_threshold;
    } front_cfg_t;

    typedef struct packed {
        logic [6:0] setpoint_limit;
        logic [7:0] servo_center;
    } back_cfg_t;

    // Head of the event queue as seen by the back end.
    typedef struct packed {
        logic       valid;
        logic [2:0] key_event;
    } queue_head_t;

endpackage

// File: sv/lkds_regs.sv
// Configuration register file behind the APB-style port.
// Depends on lkds_pkg for the register map, reset values and config structs.
module lkds_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkds_pkg::ADDR_W-1:0] paddr,
    input  logic [lkds_pkg::DATA_W-1:0] pwdata,
    output logic [lkds_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lkds_pkg::front_cfg_t        front_cfg,
    output lkds_pkg::back_cfg_t         back_cfg
);

    lkds_pkg::front_cfg_t front_cfg_reg;
    lkds_pkg::back_cfg_t  back_cfg_reg;
    logic [2:0]           reg_index;
    logic                 wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg.debounce_interval <= lkds_pkg::RST_DEBOUNCE;
            front_cfg_reg.up_threshold      <= lkds_pkg::RST_UP;
            front_cfg_reg.down_threshold    <= lkds_pkg::RST_DOWN;
            front_cfg_reg.left_threshold    <= lkds_pkg::RST_LEFT;
            front_cfg_reg.select_threshold  <= lkds_pkg::RST_SELECT;
            front_cfg_reg.release_threshold <= lkds_pkg::RST_RELEASE;
            back_cfg_reg.setpoint_limit     <= lkds_pkg::RST_LIMIT;
            back_cfg_reg.servo_center       <= lkds_pkg::RST_CENTER;
        end
        else if (wr_en)
        begin
            case (reg_index)
                lkds_pkg::REG_DEBOUNCE: front_cfg_reg.debounce_interval <= pwdata[15:0];
                lkds_pkg::REG_UP:       front_cfg_reg.up_threshold      <= pwdata[9:0];
                lkds_pkg::REG_DOWN:     front_cfg_reg.down_threshold    <= pwdata[9:0];
                lkds_pkg::REG_LEFT:     front_cfg_reg.left_threshold    <= pwdata[9:0];
                lkds_pkg::REG_SELECT:   front_cfg_reg.select_threshold  <= pwdata[9:0];
                lkds_pkg::REG_RELEASE:  front_cfg_reg.release_threshold <= pwdata[9:0];
                lkds_pkg::REG_LIMIT:    back_cfg_reg.setpoint_limit     <= pwdata[6:0];
                lkds_pkg::REG_CENTER:   back_cfg_reg.servo_center       <= pwdata[7:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            lkds_pkg::REG_DEBOUNCE: prdata = {16'd0, front_cfg_reg.debounce_interval};
            lkds_pkg::REG_UP:       prdata = {22'd0, front_cfg_reg.up_threshold};
            lkds_pkg::REG_DOWN:     prdata = {22'd0, front_cfg_reg.down_threshold};
            lkds_pkg::REG_LEFT:     prdata = {22'd0, front_cfg_reg.left_threshold};
            lkds_pkg::REG_SELECT:   prdata = {22'd0, front_cfg_reg.select_threshold};
            lkds_pkg::REG_RELEASE:  prdata = {22'd0, front_cfg_reg.release_threshold};
            lkds_pkg::REG_LIMIT:    prdata = {25'd0, back_cfg_reg.setpoint_limit};
            lkds_pkg::REG_CENTER:   prdata = {24'd0, back_cfg_reg.servo_center};
            default:                prdata = '0;
        endcase
    end

    assign front_cfg = front_cfg_reg;
    assign back_cfg  = back_cfg_reg;

endmodule

// File: sv/lkds_front.sv
// Front end: decodes the ladder reading and applies the debounce sampling.
// Depends on lkds_pkg for key codes and the front configuration struct.
module lkds_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 queue_full,
    input  logic [9:0]           adc_sample,
    input  logic [31:0]          now_ms,
    input  lkds_pkg::front_cfg_t cfg,
    output logic                 push,
    output logic [2:0]           push_event
);

    logic [2:0]  prev_key_reg;
    logic [2:0]  prev_key_next;
    logic [31:0] last_time_reg;
    logic [31:0] last_time_next;
    logic [2:0]  key;
    logic [31:0] elapsed;
    logic        due;

    // Later thresholds win, so unordered thresholds resolve by the last match.
    always_comb
    begin
        if (adc_sample >= cfg.release_threshold)
        begin
            key = lkds_pkg::KEY_NONE;
        end
        else
        begin
            key = lkds_pkg::KEY_RIGHT;
            if (adc_sample >= cfg.up_threshold)
                key = lkds_pkg::KEY_UP;
            if (adc_sample >= cfg.down_threshold)
                key = lkds_pkg::KEY_DOWN;
            if (adc_sample >= cfg.left_threshold)
                key = lkds_pkg::KEY_LEFT;
            if (adc_sample >= cfg.select_threshold)
                key = lkds_pkg::KEY_SELECT;
        end
    end

    assign elapsed = now_ms - last_time_reg;
    assign due     = elapsed > {16'd0, cfg.debounce_interval};
    assign push    = in_valid && !queue_full;

    always_comb
    begin
        push_event     = lkds_pkg::KEY_NONE;
        prev_key_next  = prev_key_reg;
        last_time_next = last_time_reg;
        if (due)
        begin
            if ((key != lkds_pkg::KEY_NONE) && (key == prev_key_reg))
                push_event = key;
            if (push)
            begin
                prev_key_next  = key;
                last_time_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg  <= lkds_pkg::KEY_NONE;
            last_time_reg <= '0;
        end
        else
        begin
            prev_key_reg  <= prev_key_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

// File: sv/lkds_fifo.sv
// Short event queue that decouples the front end from the back end.
// Depends on lkds_pkg for the queue head struct.
module lkds_fifo #(
    parameter int DEPTH = lkds_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [2:0]            push_event,
    input  logic                  pop,
    output logic                  full,
    output lkds_pkg::queue_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [2:0]       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full           = (cnt_reg == CNT_W'(DEPTH));
    assign head.valid     = (cnt_reg != '0);
    assign head.key_event = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_event;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("event pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

// File: sv/lkds_back.sv
// Back end: applies key events to the motor state and holds the output word.
// Depends on lkds_pkg for key codes and the back configuration struct.
module lkds_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkds_pkg::queue_head_t head,
    input  lkds_pkg::back_cfg_t   cfg,
    output logic                  pop,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [2:0]            key_event,
    output logic                  side_b_active,
    output logic signed [7:0]     setpoint_a,
    output logic signed [7:0]     setpoint_b,
    output logic [7:0]            servo_a,
    output logic [7:0]            servo_b
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [2:0]        event_reg;
    logic              side_reg;
    logic              side_next;
    logic signed [7:0] sp_a_reg;
    logic signed [7:0] sp_a_next;
    logic signed [7:0] sp_b_reg;
    logic signed [7:0] sp_b_next;
    logic [7:0]        servo_a_reg;
    logic [7:0]        servo_b_reg;

    // Step by one toward the limit; a setpoint at or past the limit snaps to it.
    function automatic logic signed [7:0] step_sp(input logic signed [7:0] sp,
                                                  input logic              up,
                                                  input logic [6:0]        lim);
        logic signed [8:0] sp9;
        logic signed [8:0] lim9;
        logic signed [8:0] res9;
        sp9  = {sp[7], sp};
        lim9 = {2'b00, lim};
        if (up)
            res9 = (sp9 >= lim9) ? lim9 : sp9 + 9'sd1;
        else
            res9 = (sp9 <= -lim9) ? -lim9 : sp9 - 9'sd1;
        return res9[7:0];
    endfunction

    function automatic logic [7:0] servo_of(input logic signed [7:0] sp,
                                            input logic [7:0]        center);
        logic signed [9:0] v;
        v = {{2{sp[7]}}, sp} + {2'b00, center};
        if (v < 10'sd0)
            return 8'd0;
        else if (v > 10'sd255)
            return 8'd255;
        else
            return v[7:0];
    endfunction

    // A new word is taken from the queue whenever the output register is free
    // or is being emptied in this cycle.
    assign pop = head.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        side_next = side_reg;
        sp_a_next = sp_a_reg;
        sp_b_next = sp_b_reg;
        case (head.key_event)
            lkds_pkg::KEY_RIGHT: side_next = 1'b1;
            lkds_pkg::KEY_LEFT:  side_next = 1'b0;
            lkds_pkg::KEY_UP:
            begin
                if (side_reg)
                    sp_b_next = step_sp(sp_b_reg, 1'b1, cfg.setpoint_limit);
                else
                    sp_a_next = step_sp(sp_a_reg, 1'b1, cfg.setpoint_limit);
            end
            lkds_pkg::KEY_DOWN:
            begin
                if (side_reg)
                    sp_b_next = step_sp(sp_b_reg, 1'b0, cfg.setpoint_limit);
                else
                    sp_a_next = step_sp(sp_a_reg, 1'b0, cfg.setpoint_limit);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            side_reg      <= 1'b0;
            sp_a_reg      <= '0;
            sp_b_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                side_reg <= side_next;
                sp_a_reg <= sp_a_next;
                sp_b_reg <= sp_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            event_reg   <= head.key_event;
            servo_a_reg <= servo_of(sp_a_next, cfg.servo_center);
            servo_b_reg <= servo_of(sp_b_next, cfg.servo_center);
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_event     = event_reg;
    assign side_b_active = side_reg;
    assign setpoint_a    = sp_a_reg;
    assign setpoint_b    = sp_b_reg;
    assign servo_a       = servo_a_reg;
    assign servo_b       = servo_b_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_a_reg != -8'sd128) && (sp_b_reg != -8'sd128))
        else $error("setpoint left the symmetric range");

    a_right_selects_b: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (head.key_event == lkds_pkg::KEY_RIGHT)) |=> side_reg)
        else $error("right key did not select motor B");

endmodule

// File: sv/ladder_keypad_debounced_setpoints.sv
// Top level of the ladder keypad decoder with debounce and motor setpoints.
// Depends on lkds_pkg, lkds_regs, lkds_front, lkds_fifo and lkds_back.

// The block takes one word per clock: a 10-bit ladder reading with its
// millisecond timestamp. The front end decodes the reading against the five
// thresholds and, when more than the debounce interval has passed since the
// last sample (wrapping 32-bit time), samples the key; a key counts when it
// matches the previous sample, so a held key repeats once per interval. The
// resulting event (or none) goes into a short queue, QUEUE_DEPTH words deep.
// The back end applies events in order: left picks motor A, right motor B,
// up and down step the active setpoint, clamped to plus or minus the limit,
// and the servo values are the setpoints plus the center, saturated to
// 0..255. Every input word gives exactly one output word. An accepted word
// is written into a queue slot and then moved into the output register once
// that register is free or being emptied. The block sustains one word per
// cycle while the queue is not full; the rate is set by the combinational
// decode in the front end and the single output register in the back end.
// The input is stalled only while the queue is full. Configuration is
// written through the APB-style port at byte address four times the
// register index and should only change while no words are in flight.
module ladder_keypad_debounced_setpoints #(
    parameter int QUEUE_DEPTH = lkds_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [9:0]                  adc_sample,
    input  logic [31:0]                 now_ms,
    // Output channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  key_event,
    output logic                        side_b_active,
    output logic signed [7:0]           setpoint_a,
    output logic signed [7:0]           setpoint_b,
    output logic [7:0]                  servo_a,
    output logic [7:0]                  servo_b,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkds_pkg::ADDR_W-1:0] paddr,
    input  logic [lkds_pkg::DATA_W-1:0] pwdata,
    output logic [lkds_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    lkds_pkg::front_cfg_t  front_cfg;
    lkds_pkg::back_cfg_t   back_cfg;
    lkds_pkg::queue_head_t head;
    logic                  queue_full;
    logic                  push;
    logic [2:0]            push_event;
    logic                  pop;

    // The input is held off only by a full queue, never by the output side
    // directly, so a waiting result does not block new words.
    assign in_stall = queue_full;

    lkds_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .front_cfg (front_cfg),
        .back_cfg  (back_cfg)
    );

    lkds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .adc_sample (adc_sample),
        .now_ms     (now_ms),
        .cfg        (front_cfg),
        .push       (push),
        .push_event (push_event)
    );

    lkds_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .full       (queue_full),
        .head       (head)
    );

    lkds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .cfg           (back_cfg),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .key_event     (key_event),
        .side_b_active (side_b_active),
        .setpoint_a    (setpoint_a),
        .setpoint_b    (setpoint_b),
        .servo_a       (servo_a),
        .servo_b       (servo_b)
    );

endmodule
